@@ rtl/ook_pkg.sv @@
// ook_pkg: shared types, constants and the frame symbol mapping for the
// on-off-keyed command frame encoder. No dependencies.

package ook_pkg;

  localparam int unsigned FrameBytes   = 45;
  localparam int unsigned BurstSyms    = 180;
  localparam int unsigned FrameSyms    = 2 * BurstSyms;
  localparam int unsigned PayloadBits  = 28;
  localparam int unsigned PreambleLen  = 9;
  localparam int unsigned SymLen       = 3;
  localparam int unsigned IdWidth      = 16;
  localparam int unsigned CmdWidth     = 8;
  localparam int unsigned IdxWidth     = 6;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [IdxWidth-1:0]    LastIdx  = IdxWidth'(FrameBytes - 1);
  localparam logic [PreambleLen-1:0] Preamble = 9'b111000111;
  localparam logic [3:0]             Nibble   = 4'b1000;
  localparam logic [SymLen-1:0]      SymOne   = 3'b001;
  localparam logic [SymLen-1:0]      SymZero  = 3'b011;
  localparam logic [SymLen-1:0]      SymGap   = 3'b000;

  typedef logic [PayloadBits-1:0] payload_t;

  typedef struct packed {
    logic                last_byte;
    logic [IdxWidth-1:0] byte_index;
    logic [7:0]          frame_byte;
  } ook_beat_t;

  // one burst: preamble, payload twice, gap; earliest symbol in the msb
  function automatic logic [BurstSyms-1:0] build_burst(input payload_t payload);
    logic [BurstSyms-1:0] b;
    logic [SymLen-1:0]    code;
    b = '0;
    b[BurstSyms-1 -: PreambleLen] = Preamble;
    for (int j = 0; j < PayloadBits; j++) begin
      code = payload[PayloadBits-1-j] ? SymOne : SymZero;
      b[BurstSyms-1-PreambleLen-SymLen*j -: SymLen] = code;
      b[BurstSyms-1-PreambleLen-SymLen*(PayloadBits+j) -: SymLen] = code;
    end
    b[SymLen-1:0] = SymGap;
    return b;
  endfunction

  function automatic logic [7:0] pick_byte(input payload_t payload,
                                           input logic [IdxWidth-1:0] idx);
    logic [BurstSyms-1:0] burst;
    logic [FrameSyms-1:0] frm;
    logic [8:0]           top;
    burst = build_burst(payload);
    frm   = {burst, burst};
    top   = 9'(FrameSyms - 1) - {idx, 3'b000};
    return frm[top -: 8];
  endfunction

endpackage

@@ rtl/ook_pwm_command_frame_encoder.sv @@
// ook_pwm_command_frame_encoder: top level of the command frame encoder.
// Depends on ook_pkg, ook_src and ook_out.

// Each accepted command beat yields a 360-symbol frame as 45 output beats,
// one byte per cycle while the output is not stalled, earliest symbol in the
// msb, byte_index counting 0 to 44 and tlast on the final byte. A command
// therefore holds the stepper until its byte counter reaches the last byte; the
// next command is taken in the cycle the last byte moves to the output
// register, so frames follow each other without gaps. The device id written
// on the configuration channel is sampled when a command is accepted.

module ook_pwm_command_frame_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ook_pkg::IdWidth-1:0]        cfg_data_i,       // device_id
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [ook_pkg::CmdWidth-1:0]       s_axis_tdata_i,   // command_code
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [ook_pkg::OutDataWidth-1:0]   m_axis_tdata_o,   // frame_byte, byte_index
  output logic                               m_axis_tlast_o    // last_byte
);

  logic [ook_pkg::IdWidth-1:0] device_id_q;
  logic                        beat_valid;
  logic                        beat_ready;
  ook_pkg::ook_beat_t          src_beat;
  ook_pkg::ook_beat_t          out_beat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      device_id_q <= cfg_data_i;
    end
  end

  ook_src u_src (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .device_id_i    (device_id_q),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .command_code_i (s_axis_tdata_i),
    .beat_valid_o   (beat_valid),
    .beat_ready_i   (beat_ready),
    .beat_o         (src_beat)
  );

  ook_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_ready_o (beat_ready),
    .beat_i       (src_beat),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .beat_o       (out_beat)
  );

  assign m_axis_tdata_o = {2'b00, out_beat.byte_index, out_beat.frame_byte};
  assign m_axis_tlast_o = out_beat.last_byte;

endmodule

@@ rtl/ook_src.sv @@
// ook_src: holds the payload of the current command and steps through the
// 45 frame bytes. Depends on ook_pkg.

module ook_src (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ook_pkg::IdWidth-1:0]     device_id_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ook_pkg::CmdWidth-1:0]    command_code_i,
  output logic                            beat_valid_o,
  input  logic                            beat_ready_i,
  output ook_pkg::ook_beat_t              beat_o
);

  logic                            busy_q, busy_d;
  logic [ook_pkg::IdxWidth-1:0]    idx_q, idx_d;
  ook_pkg::payload_t               payload_q, payload_d;
  logic                            adv;
  logic                            last;
  logic                            take;

  assign last         = (idx_q == ook_pkg::LastIdx);
  assign adv          = busy_q && beat_ready_i;
  assign in_ready_o   = !busy_q || (adv && last);
  assign take         = in_valid_i && in_ready_o;
  assign beat_valid_o = busy_q;

  assign beat_o.frame_byte = ook_pkg::pick_byte(payload_q, idx_q);
  assign beat_o.byte_index = idx_q;
  assign beat_o.last_byte  = last;

  always_comb begin
    busy_d    = busy_q;
    idx_d     = idx_q;
    payload_d = payload_q;
    priority if (take) begin
      busy_d    = 1'b1;
      idx_d     = '0;
      payload_d = {device_id_i, ook_pkg::Nibble, command_code_i};
    end else if (adv) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

endmodule

@@ rtl/ook_out.sv @@
// ook_out: output register stage for frame beats, decoupling the byte
// stepper from downstream stalls. Depends on ook_pkg.

module ook_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_valid_i,
  output logic                 beat_ready_o,
  input  ook_pkg::ook_beat_t   beat_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output ook_pkg::ook_beat_t   beat_o
);

  logic               valid_q, valid_d;
  ook_pkg::ook_beat_t beat_q;
  logic               load;

  assign beat_ready_o = !valid_q || ready_i;
  assign load         = beat_valid_i && beat_ready_o;
  assign valid_d      = load ? 1'b1 : (valid_q && !ready_i);
  assign valid_o      = valid_q;
  assign beat_o       = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

endmodule

@@ rtl/ook_chk.sv @@
// ook_chk: port-level checker for the command frame encoder, bound to the
// top level. Depends on ook_pkg and ook_pwm_command_frame_encoder.

module ook_chk (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tready_o,
  input  logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  input  logic [ook_pkg::OutDataWidth-1:0]   m_axis_tdata_o,
  input  logic                               m_axis_tlast_o
);

  logic [ook_pkg::IdxWidth-1:0] idx;
  logic                         m_beat;

  assign idx    = m_axis_tdata_o[8 +: ook_pkg::IdxWidth];
  assign m_beat = m_axis_tvalid_o && m_axis_tready_i;

  a_last_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (idx == ook_pkg::LastIdx)))
    else $error("tlast disagrees with byte index");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled output beat changed");

  // a stalled mid-frame beat means the frame is still in progress
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("command accepted mid-frame");

  a_bytes_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_beat && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (idx == $past(idx) + 1'b1)))
    else $error("frame bytes not contiguous");

endmodule

bind ook_pwm_command_frame_encoder ook_chk u_ook_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
